// ===== rtl/core/rrbcd_pkg.sv =====
package rrbcd_pkg;

  localparam int SLOTS = 16;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam int KEY_W = 64;
  localparam int SIZE_W = 17;
  localparam int SLOT_OUT_W = 4;
  localparam int HIT_W = 32;
  localparam int BYTE_W = 48;

  localparam logic [SIZE_W-1:0] CAPACITY_RESET = 17'h10000;

  typedef enum logic {
    KIND_LOOKUP = 1'b0,
    KIND_STORE  = 1'b1
  } kind_t;

  // item held in the input register
  typedef struct packed {
    logic              valid;
    kind_t             kind;
    logic [KEY_W-1:0]  key;
    logic [SIZE_W-1:0] block_size;
  } item_t;

  // directory answer handed to the result register
  typedef struct packed {
    logic                  valid;
    kind_t                 kind;
    logic                  hit;
    logic                  stored;
    logic [SLOT_OUT_W-1:0] slot;
    logic [SIZE_W-1:0]     size;
    logic                  evicted_valid;
    logic [KEY_W-1:0]      evicted_key;
    logic [SIZE_W-1:0]     block_size;
  } dir_res_t;

  // low bits of a slot number as shown on the result port
  function automatic logic [SLOT_OUT_W-1:0] slot_out(input logic [SLOT_W-1:0] idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return wide[SLOT_OUT_W-1:0];
  endfunction

endpackage

// ===== rtl/core/round_robin_block_cache_directory.sv =====
// Directory of a fully associative block cache of 16 slots with rotating
// replacement. Raise start with kind, key and block_size; the transfer takes
// place at any clock edge where start is high and busy is low. busy is high
// only during reset, so one command may be issued every cycle. Each command
// gives exactly one result, shown for a single cycle while done is high; the
// receiver cannot stall, so capture it then. Each command passes the input
// register and the result register, with the parallel key compare and the
// replacement logic between them; throughput is one command per cycle.
// A lookup (kind 0) returns hit, the slot and stored
// size of the newest matching copy, or zeros on a miss. A store (kind 1) adds
// block_size to byte_count; if block_size does not exceed slot_capacity it
// overwrites the slot at the cursor, reports the previous occupant through
// evicted_valid and evicted_key, and advances the cursor. A larger block is
// refused: stored low, slot shows the cursor, nothing else changes. Write
// slot_capacity (reset 65536) with slot_capacity_we only while no command
// is in flight. hit_count, miss_count and byte_count show the counters after
// the command and wrap. No clearing pass is needed after reset.
module round_robin_block_cache_directory
  import rrbcd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  kind,
  input  logic [KEY_W-1:0]      key,
  input  logic [SIZE_W-1:0]     block_size,
  input  logic                  slot_capacity_we,
  input  logic [SIZE_W-1:0]     slot_capacity,
  output logic                  done,
  output logic                  hit,
  output logic                  stored,
  output logic [SLOT_OUT_W-1:0] slot,
  output logic [SIZE_W-1:0]     size,
  output logic                  evicted_valid,
  output logic [KEY_W-1:0]      evicted_key,
  output logic [HIT_W-1:0]      hit_count,
  output logic [HIT_W-1:0]      miss_count,
  output logic [BYTE_W-1:0]     byte_count
);

  item_t    item;
  dir_res_t res;
  logic     accept;

  // hold off commands only while reset clears the pipeline
  assign busy   = rst;
  assign accept = start && !busy;

  rrbcd_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .kind       (kind),
    .key        (key),
    .block_size (block_size),
    .item       (item)
  );

  // compare, pick newest match, replace at cursor
  rrbcd_directory u_directory (
    .clk              (clk),
    .rst              (rst),
    .slot_capacity_we (slot_capacity_we),
    .slot_capacity    (slot_capacity),
    .item             (item),
    .res              (res)
  );

  // register the result and advance the counters
  rrbcd_result u_result (
    .clk           (clk),
    .rst           (rst),
    .res           (res),
    .done          (done),
    .hit           (hit),
    .stored        (stored),
    .slot          (slot),
    .size          (size),
    .evicted_valid (evicted_valid),
    .evicted_key   (evicted_key),
    .hit_count     (hit_count),
    .miss_count    (miss_count),
    .byte_count    (byte_count)
  );

endmodule

// ===== rtl/core/rrbcd_in_stage.sv =====
module rrbcd_in_stage
  import rrbcd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic                kind,
  input  logic [KEY_W-1:0]    key,
  input  logic [SIZE_W-1:0]   block_size,
  output item_t               item
);

  logic              valid;
  kind_t             kind_q;
  logic [KEY_W-1:0]  key_q;
  logic [SIZE_W-1:0] size_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= accept;
    end
  end

  // capture the payload on every transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q <= kind_t'(kind);
      key_q  <= key;
      size_q <= block_size;
    end
  end

  assign item = '{valid: valid, kind: kind_q, key: key_q, block_size: size_q};

endmodule

// ===== rtl/core/rrbcd_directory.sv =====
module rrbcd_directory
  import rrbcd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              slot_capacity_we,
  input  logic [SIZE_W-1:0] slot_capacity,
  input  item_t             item,
  output dir_res_t          res
);

  logic [KEY_W-1:0]  slot_keys  [SLOTS];
  logic [SIZE_W-1:0] slot_sizes [SLOTS];
  logic [SLOTS-1:0]  slot_valid;
  logic [SLOT_W-1:0] cursor;
  logic [SLOT_W-1:0] cursor_next;
  logic [SIZE_W-1:0] capacity;

  logic [SLOTS-1:0]  match;
  logic              found;
  logic [SLOT_W-1:0] best;
  logic              fits;
  logic              do_write;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (slot_capacity_we) begin
      capacity <= slot_capacity;
    end
  end

  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      match[s] = slot_valid[s] && (slot_keys[s] == item.key);
    end
  end

  // walk from the cursor round the ring; the last match seen is the newest copy
  always_comb begin
    logic [SLOT_W:0] sum;
    found = 1'b0;
    best  = '0;
    for (int i = 0; i < SLOTS; i++) begin
      sum = (SLOT_W+1)'(cursor) + (SLOT_W+1)'(i);
      if (sum >= (SLOT_W+1)'(SLOTS)) begin
        sum = sum - (SLOT_W+1)'(SLOTS);
      end
      if (match[sum[SLOT_W-1:0]]) begin
        found = 1'b1;
        best  = sum[SLOT_W-1:0];
      end
    end
  end

  assign fits     = item.block_size <= capacity;
  assign do_write = item.valid && (item.kind == KIND_STORE) && fits;

  always_comb begin
    if (cursor == SLOT_W'(SLOTS - 1)) begin
      cursor_next = '0;
    end else begin
      cursor_next = cursor + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      cursor     <= '0;
    end else if (do_write) begin
      slot_valid[cursor] <= 1'b1;
      cursor             <= cursor_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      slot_keys[cursor]  <= item.key;
      slot_sizes[cursor] <= item.block_size;
    end
  end

  always_comb begin
    res               = '0;
    res.valid         = item.valid;
    res.kind          = item.kind;
    res.block_size    = item.block_size;
    case (item.kind)
      KIND_LOOKUP: begin
        if (found) begin
          res.hit  = 1'b1;
          res.slot = slot_out(best);
          res.size = slot_sizes[best];
        end
      end
      KIND_STORE: begin
        res.slot = slot_out(cursor);
        if (fits) begin
          res.stored        = 1'b1;
          res.size          = item.block_size;
          res.evicted_valid = slot_valid[cursor];
          res.evicted_key   = slot_valid[cursor] ? slot_keys[cursor] : '0;
        end
      end
      default: begin
        res.slot = '0;
      end
    endcase
  end

endmodule

// ===== rtl/core/rrbcd_result.sv =====
module rrbcd_result
  import rrbcd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  dir_res_t              res,
  output logic                  done,
  output logic                  hit,
  output logic                  stored,
  output logic [SLOT_OUT_W-1:0] slot,
  output logic [SIZE_W-1:0]     size,
  output logic                  evicted_valid,
  output logic [KEY_W-1:0]      evicted_key,
  output logic [HIT_W-1:0]      hit_count,
  output logic [HIT_W-1:0]      miss_count,
  output logic [BYTE_W-1:0]     byte_count
);

  logic is_lookup;
  logic is_store;

  assign is_lookup = res.valid && (res.kind == KIND_LOOKUP);
  assign is_store  = res.valid && (res.kind == KIND_STORE);

  always_ff @(posedge clk) begin
    if (rst) begin
      done       <= 1'b0;
      hit_count  <= '0;
      miss_count <= '0;
      byte_count <= '0;
    end else begin
      done <= res.valid;
      if (is_lookup && res.hit) begin
        hit_count <= hit_count + HIT_W'(1);
      end
      if (is_lookup && !res.hit) begin
        miss_count <= miss_count + HIT_W'(1);
      end
      // refused stores still count their bytes
      if (is_store) begin
        byte_count <= byte_count + BYTE_W'(res.block_size);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      hit           <= res.hit;
      stored        <= res.stored;
      slot          <= res.slot;
      size          <= res.size;
      evicted_valid <= res.evicted_valid;
      evicted_key   <= res.evicted_key;
    end
  end

endmodule

// ===== rtl/core/rrbcd_checker.sv =====
module rrbcd_checker
  import rrbcd_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input logic              hit,
  input logic              stored,
  input logic              evicted_valid,
  input logic [HIT_W-1:0]  hit_count,
  input logic [HIT_W-1:0]  miss_count
);

  // a result is shown when, and only when, a transfer has passed the input register and the result register
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done == $past(start && !busy, 2))
    else $error("result strobe does not follow a transfer by two cycles");

  a_kind_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(hit && stored))
    else $error("result reports both a hit and a store");

  a_evict: assert property (@(posedge clk) disable iff (rst)
    (done && !stored) |-> !evicted_valid)
    else $error("eviction reported without a store");

  a_hit_cnt: assert property (@(posedge clk) disable iff (rst)
    (hit_count != $past(hit_count)) |-> (done && hit))
    else $error("hit counter moved without a hit");

  a_miss_cnt: assert property (@(posedge clk) disable iff (rst)
    (miss_count != $past(miss_count)) |-> (done && !hit && !stored))
    else $error("miss counter moved without a miss");

endmodule

bind round_robin_block_cache_directory rrbcd_checker u_rrbcd_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .hit           (hit),
  .stored        (stored),
  .evicted_valid (evicted_valid),
  .hit_count     (hit_count),
  .miss_count    (miss_count)
);
